// File: hw/rtl/matrix_inverse_4x4_defines.svh
// ---------------------------------------------------------------------------
// matrix_inverse_4x4_defines
// Assertion macros shared by the inverter RTL.
// ---------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_DEFINES_SVH
`define MATRIX_INVERSE_4X4_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define MI4_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MI4_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mi4_pkg.sv
// ---------------------------------------------------------------------------
// mi4_pkg
// Types, widths and helper functions of the 4x4 matrix inverter.
// ---------------------------------------------------------------------------
package mi4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EW = 32;   // element width
  localparam int PW = 128;  // product magnitude register
  localparam int CW = 97;   // signed cofactor
  localparam int DW = 131;  // signed determinant
  localparam int QW = 33;   // quotient bits kept

  typedef logic [15:0][EW-1:0] mat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // n-th index of {0,1,2,3} with skip removed
  function automatic logic [1:0] pick(input logic [1:0] skip, input logic [1:0] n);
    pick = (n < skip) ? n : n + 2'd1;
  endfunction

  // column choice of permutation p for minor row i
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
    logic [5:0] row;
    case (p)
      3'd0: row = {2'd2, 2'd1, 2'd0};
      3'd1: row = {2'd0, 2'd2, 2'd1};
      3'd2: row = {2'd1, 2'd0, 2'd2};
      3'd3: row = {2'd1, 2'd2, 2'd0};
      3'd4: row = {2'd0, 2'd1, 2'd2};
      3'd5: row = {2'd2, 2'd0, 2'd1};
      default: row = '0;
    endcase
    perm_col = row[{i, 1'b0} +: 2];
  endfunction

  // odd permutations subtract
  function automatic logic perm_neg(input logic [2:0] p);
    perm_neg = (p >= 3'd3);
  endfunction

endpackage

// File: hw/rtl/mi4_front.sv
// ---------------------------------------------------------------------------
// mi4_front
// Collects sixteen words into a matrix and pushes it to the queue.
// ---------------------------------------------------------------------------
module mi4_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mi4_pkg::EW-1:0]     s_tdata,
  input  mi4_pkg::q_stat_t           qs,
  output logic                       push,
  output mi4_pkg::mat_t              push_data
);
  import mi4_pkg::*;

  logic [3:0]          load_count;
  logic [14:0][EW-1:0] matrix_store;
  logic                take;

  assign s_tready = (load_count != 4'd15) || !qs.full;
  assign take     = s_tvalid && s_tready;
  assign push     = take && (load_count == 4'd15);
  assign push_data = {s_tdata, matrix_store};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (take) begin
      load_count <= load_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (load_count != 4'd15)) begin
      matrix_store[load_count] <= s_tdata;
    end
  end

endmodule

// File: hw/rtl/mi4_queue.sv
// ---------------------------------------------------------------------------
// mi4_queue
// Two-entry matrix queue between front and back.
// ---------------------------------------------------------------------------
module mi4_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mi4_pkg::mat_t     push_data,
  input  logic              pop,
  output mi4_pkg::mat_t     head,
  output mi4_pkg::q_stat_t  qs
);
  import mi4_pkg::*;

  mat_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign qs.full  = (count == 2'd2);
  assign qs.empty = (count == 2'd0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/mi4_back.sv
// ---------------------------------------------------------------------------
// mi4_back
// Cofactors, determinant and per-element division with one 32x32
// multiplier and a radix-2 divider; drives the output register.
// ---------------------------------------------------------------------------
module mi4_back #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mi4_pkg::mat_t        head,
  input  mi4_pkg::q_stat_t     qs,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);
  import mi4_pkg::*;

  localparam int NW = 96 + 2 * FRAC_BITS;
  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MUL, S_ACC, S_STORE, S_DFETCH, S_DACC,
    S_CHECK, S_DSTART, S_DIV, S_EMIT, S_DONE
  } state_t;

  state_t               state;
  logic [3:0]           k;
  logic [2:0]           p;
  logic [1:0]           i;
  logic [1:0]           limb;
  logic [1:0]           limb_last;
  logic                 ph_det;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        mres;
  logic [EW-1:0]        m_op;
  logic                 sgn;
  logic signed [CW-1:0] cof_acc;
  logic signed [CW-1:0] adj [16];
  logic signed [DW-1:0] det;
  logic [DW-1:0]        dmag;
  logic                 dneg;
  logic [DW-1:0]        rem;
  logic [QW-1:0]        numr;
  logic [QW-1:0]        q;
  logic [5:0]           step;
  logic                 big;
  logic                 qneg;

  logic [1:0]    row, col;
  logic [EW-1:0] e, e_mag;
  logic [63:0]   part;
  logic [PW-1:0] mres_next;
  logic [CW-1:0] c_sel, c_mag;
  logic [CW-1:0] cj, cj_mag;
  logic [EW-1:0] ej;
  logic [EW-1:0] ej_mag;
  logic [NW-1:0] num;
  logic          num_big;
  logic [DW:0]   rem2;
  logic          qbit;
  logic [QW-1:0] lim;
  logic          sat;
  logic [EW-1:0] q32, val;
  logic          out_free;
  logic          out_load;

  always_comb begin
    row   = pick(k[3:2], i);
    col   = pick(k[1:0], perm_col(p, i));
    e     = head[{col, row}];
    e_mag = e[EW-1] ? (EW'(0) - e) : e;
    part  = 64'(prod[{limb, 5'd0} +: EW]) * 64'(m_op);
    mres_next = mres + ({64'd0, part} << {limb, 5'd0});
    cj     = adj[{k[1:0], 2'b00}];
    cj_mag = cj[CW-1] ? (CW'(0) - cj) : cj;
    ej     = head[{2'b00, k[1:0]}];
    ej_mag = ej[EW-1] ? (EW'(0) - ej) : ej;
    c_sel  = adj[k];
    c_mag  = c_sel[CW-1] ? (CW'(0) - c_sel) : c_sel;
    num     = NW'(c_mag[CW-2:0]) << (2 * FRAC_BITS);
    num_big = XW'(num) >= (XW'(dmag) << QW);
    rem2 = {rem, numr[QW-1]};
    qbit = rem2 >= {1'b0, dmag};
    lim  = qneg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
    sat  = big || (q > lim);
    q32  = sat ? lim[EW-1:0] : q[EW-1:0];
    val  = qneg ? (EW'(0) - q32) : q32;
    out_free = !m_tvalid || m_tready;
    out_load = out_free && ((state == S_EMIT) || ((state == S_CHECK) && (det == '0)));
  end

  assign pop = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            k       <= '0;
            p       <= '0;
            i       <= '0;
            ph_det  <= 1'b0;
            cof_acc <= '0;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (i == 2'd0) begin
            prod <= PW'(e_mag);
            sgn  <= e[EW-1] ^ perm_neg(p) ^ k[2] ^ k[0];
            i    <= 2'd1;
          end else begin
            m_op      <= e_mag;
            sgn       <= sgn ^ e[EW-1];
            mres      <= '0;
            limb      <= '0;
            limb_last <= i - 2'd1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          mres <= mres_next;
          limb <= limb + 2'd1;
          if (limb == limb_last) begin
            prod <= mres_next;
            if (ph_det) begin
              state <= S_DACC;
            end else if (i == 2'd2) begin
              state <= S_ACC;
            end else begin
              i     <= i + 2'd1;
              state <= S_FETCH;
            end
          end
        end
        S_ACC: begin
          cof_acc <= sgn ? cof_acc - $signed(prod[CW-1:0])
                         : cof_acc + $signed(prod[CW-1:0]);
          i <= '0;
          if (p == 3'd5) begin
            state <= S_STORE;
          end else begin
            p     <= p + 3'd1;
            state <= S_FETCH;
          end
        end
        S_STORE: begin
          adj[k]  <= cof_acc;
          cof_acc <= '0;
          p       <= '0;
          if (k == 4'd15) begin
            k      <= '0;
            det    <= '0;
            ph_det <= 1'b1;
            state  <= S_DFETCH;
          end else begin
            k     <= k + 4'd1;
            state <= S_FETCH;
          end
        end
        S_DFETCH: begin
          prod      <= PW'(cj_mag);
          m_op      <= ej_mag;
          sgn       <= cj[CW-1] ^ ej[EW-1];
          mres      <= '0;
          limb      <= '0;
          limb_last <= 2'd3;
          state     <= S_MUL;
        end
        S_DACC: begin
          det <= sgn ? det - $signed(DW'(prod)) : det + $signed(DW'(prod));
          if (k == 4'd3) begin
            state <= S_CHECK;
          end else begin
            k     <= k + 4'd1;
            state <= S_DFETCH;
          end
        end
        S_CHECK: begin
          if (det == '0) begin
            if (out_free) begin
              m_tdata  <= '0;
              m_tuser  <= 2'b01;
              m_tlast  <= 1'b1;
              state    <= S_DONE;
            end
          end else begin
            dneg  <= det[DW-1];
            dmag  <= det[DW-1] ? (DW'(0) - det) : det;
            k     <= '0;
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          qneg <= c_sel[CW-1] ^ dneg;
          big  <= num_big;
          q    <= '0;
          rem  <= DW'(num >> QW);
          numr <= num[QW-1:0];
          step <= '0;
          state <= num_big ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          rem  <= qbit ? DW'(rem2 - {1'b0, dmag}) : rem2[DW-1:0];
          numr <= numr << 1;
          q    <= {q[QW-2:0], qbit};
          step <= step + 6'd1;
          if (step == 6'(QW - 1)) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= {4'd0, k, val};
            m_tuser  <= {sat, 1'b0};
            m_tlast  <= (k == 4'd15);
            if (k == 4'd15) begin
              state <= S_DONE;
            end else begin
              k     <= k + 4'd1;
              state <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/matrix_inverse_4x4.sv
// ---------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by cofactors and the adjugate.
// ---------------------------------------------------------------------------
//  channel  dir  bits                 contents
//  s_*      in   tdata[31:0]          matrix element, column-major
//  m_*      out  tdata[39:0]          inverse element, index; tuser flags;
//                                     tlast on last word of the matrix
//
// Arithmetic: the single shared 32x32 multiplier forms the cofactors and the
// determinant, and the radix-2 divider forms each result word.
// Reset: rst synchronous, active high; clears counters, queue and FSM.
// Stalls: front keeps loading while the back works; a two-matrix queue
// sits between them, and the output register holds while m_tready is low.
// ---------------------------------------------------------------------------
`include "matrix_inverse_4x4_defines.svh"

module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] matrix_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] inverse_element, [35:32] element_index, pad
  output logic [1:0]  m_tuser,   // [0] singular, [1] saturated
  output logic        m_tlast    // last_of_matrix
);
  import mi4_pkg::*;

  q_stat_t qs;
  logic    push;
  logic    pop;
  mat_t    push_data;
  mat_t    head;

  // front: word counter and load buffer
  mi4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .qs        (qs),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue of whole matrices
  mi4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  // back: arithmetic sequencer and output register
  mi4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qs       (qs),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // singular word is alone: zero data, index 0, last
  `MI4_ASSERT_IMP(a_singular_word, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 40'd0) && !m_tuser[1], "singular word malformed")
  // a regular matrix ends only on index 15
  `MI4_ASSERT_IMP(a_last_index, m_tvalid && !m_tuser[0] && m_tlast, m_tdata[35:32] == 4'd15, "tlast on wrong index")
  // input stalls only when the queue is full
  `MI4_ASSERT_IMP(a_stall_full, !s_tready, qs.full, "input stalled with queue space")
  // a push never lands on a queue that was already full
  `MI4_ASSERT_NXT(a_push_room, push, !(qs.full && $past(qs.full) && !$past(pop)), "queue overrun")

endmodule

// File: tb/matrix_inverse_4x4_tb.sv
// ---------------------------------------------------------------------------
// matrix_inverse_4x4_tb
// Self-checking bench for the 4x4 fixed-point inverter. Matrices are streamed
// in column-major order. A bit-accurate adjugate/determinant predictor
// queues the expected inverse words, and the monitor checks every output word
// against that queue. Both sides insert random idle cycles. One phase holds
// off the output side for a long time, and one phase drains all results
// before the next matrix goes in.
// ---------------------------------------------------------------------------
module matrix_inverse_4x4_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = mi4_pkg::FRAC_BITS_DEF;
  localparam longint LIMIT = 2_000_000;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        singular;
    logic        saturated;
    logic        last;
  } inv_word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  matrix_inverse_4x4 dut (.*);

  logic [31:0] elem_queue[$];   // words waiting to be driven
  inv_word_t   inverse_queue[$];  // expected inverse words
  logic [31:0] shadow[16];
  int          load_idx = 0;
  int          errors = 0;
  int          matrices = 0, words_seen = 0, sing_seen = 0, sat_seen = 0;
  longint      cycles = 0;
  bit          hold_rx = 0;     // long receiver hold-off

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("matrix_inverse_4x4_tb: done, errors");
      $finish;
    end
  end

  // 3x3 minor, exact, times the cofactor sign
  function automatic logic signed [127:0] cofac(input int r, input int c);
    int rr[3], cc[3];
    int nr, nc;
    logic signed [127:0] acc, t;
    nr = 0; nc = 0; acc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin rr[nr] = i; nr++; end
      if (i != c) begin cc[nc] = i; nc++; end
    end
    for (int p = 0; p < 3; p++) begin
      // even permutations
      t = 128'(signed'(shadow[cc[p]*4 + rr[0]]))
        * 128'(signed'(shadow[cc[(p+1)%3]*4 + rr[1]]))
        * 128'(signed'(shadow[cc[(p+2)%3]*4 + rr[2]]));
      acc = acc + t;
      // odd permutations
      t = 128'(signed'(shadow[cc[p]*4 + rr[0]]))
        * 128'(signed'(shadow[cc[(p+2)%3]*4 + rr[1]]))
        * 128'(signed'(shadow[cc[(p+1)%3]*4 + rr[2]]));
      acc = acc - t;
    end
    if ((r + c) % 2) acc = -acc;
    return acc;
  endfunction

  task automatic predict_inverse();
    logic signed [255:0] adj[16];
    logic signed [255:0] det, num;
    logic        [255:0] q, nmag, dmag;
    logic neg;
    inv_word_t w;
    det = 0;
    // inverse index c*4+r takes the cofactor of row c, column r
    for (int k = 0; k < 16; k++) adj[k] = 256'(cofac(k / 4, k % 4));
    for (int i = 0; i < 4; i++)
      det = det + adj[i*4] * 256'(signed'(shadow[i]));
    if (det == 0) begin
      w = '{value: '0, index: '0, singular: 1'b1, saturated: 1'b0, last: 1'b1};
      inverse_queue.push_back(w);
      return;
    end
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < 16; k++) begin
      num = adj[k];
      nmag = (num < 0 ? -num : num) << (2 * FB);
      q = nmag / dmag;
      neg = (num < 0) != (det < 0);
      w.index = k[3:0];
      w.singular = 0;
      w.last = (k == 15);
      w.saturated = 0;
      if (!neg && q > 256'h7FFF_FFFF) begin
        q = 256'h7FFF_FFFF; w.saturated = 1;
      end else if (neg && q > 256'h8000_0000) begin
        q = 256'h8000_0000; w.saturated = 1;
      end
      w.value = neg ? 32'(-q) : q[31:0];
      inverse_queue.push_back(w);
    end
  endtask

  // driver: one word per handshake, random gaps
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (s_tvalid && s_tready) begin
      shadow[load_idx] = s_tdata;
      if (load_idx == 15) begin
        predict_inverse();
        matrices++;
        load_idx = 0;
      end else begin
        load_idx++;
      end
      void'(elem_queue.pop_front());
      tx_gap = $urandom_range(0, 15);
      if (tx_gap == 0 && elem_queue.size() > 0 && ($urandom_range(0, 2) != 0)) begin
        s_tdata <= elem_queue[0];
      end else begin
        s_tvalid <= 0;
      end
    end else if (!s_tvalid) begin
      if (tx_gap > 0) tx_gap--;
      else if (elem_queue.size() > 0) begin
        s_tvalid <= 1;
        s_tdata <= elem_queue[0];
      end
    end
  end

  // monitor and receiver stalls
  int rx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        inv_word_t got, exp_w;
        got = '{value: m_tdata[31:0], index: m_tdata[35:32], singular: m_tuser[0],
                saturated: m_tuser[1], last: m_tlast};
        words_seen++;
        if (got.singular) sing_seen++;
        if (got.saturated) sat_seen++;
        if (inverse_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          exp_w = inverse_queue.pop_front();
          if (got.value !== exp_w.value)
            $display("%0t: value idx %0d exp %h got %h", $time, exp_w.index,
                     exp_w.value, got.value);
          if (got.index !== exp_w.index)
            $display("%0t: index exp %0d got %0d", $time, exp_w.index, got.index);
          if (got.singular !== exp_w.singular)
            $display("%0t: singular exp %b got %b", $time, exp_w.singular, got.singular);
          if (got.saturated !== exp_w.saturated)
            $display("%0t: saturated idx %0d exp %b got %b", $time, exp_w.index,
                     exp_w.saturated, got.saturated);
          if (got.last !== exp_w.last)
            $display("%0t: last exp %b got %b", $time, exp_w.last, got.last);
          if (got !== exp_w) errors++;
        end
        rx_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) rx_gap = 0;
        if (rx_gap > 0 || hold_rx) m_tready <= 0;
      end else if (!m_tready) begin
        if (hold_rx) ;
        else if (rx_gap > 0) rx_gap--;
        else m_tready <= 1;
      end
    end
  end

  // long hold-off, counted here
  initial begin
    wait (matrices >= 2);
    hold_rx = 1;
    repeat (6000) @(posedge clk);
    hold_rx = 0;
  end

  function automatic logic [31:0] rand_elem(input int mode);
    case (mode)
      0: return $urandom();                                        // full range
      1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB)); // moderate
      default: return 32'($signed($urandom_range(0, 64)) - 32);     // tiny, sats
    endcase
  endfunction

  task automatic add_matrix(input logic [31:0] m[16]);
    for (int i = 0; i < 16; i++) elem_queue.push_back(m[i]);
  endtask

  task automatic drain();
    while (elem_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (inverse_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] m[16];
    int mode;
    repeat (2) @(posedge clk);
    rst <= 0;
    // identity
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'(1 << FB) : 0;
    add_matrix(m);
    // extremes on the diagonal: tiny, max and most negative -> saturation
    for (int i = 0; i < 16; i++) m[i] = 0;
    m[0] = 32'h0000_0001; m[5] = 32'h7FFF_FFFF; m[10] = 32'h8000_0000;
    m[15] = 32'hFFFF_FFFF;
    add_matrix(m);
    // all zero: singular
    for (int i = 0; i < 16; i++) m[i] = 0;
    add_matrix(m);
    drain();
    // repeated column: singular with nonzero content; pause until drained
    for (int i = 0; i < 16; i++) m[i] = $urandom();
    for (int r = 0; r < 4; r++) m[4 + r] = m[r];
    add_matrix(m);
    drain();
    repeat (1500) @(posedge clk);
    for (int n = 0; n < 10; n++) begin
      mode = $urandom_range(0, 5);
      for (int i = 0; i < 16; i++) m[i] = rand_elem(mode % 3);
      if (mode == 5) for (int r = 0; r < 4; r++) m[8 + r] = m[12 + r]; // singular
      add_matrix(m);
    end
    drain();
    repeat (1500) @(posedge clk);
    $display("ran %0d matrices, %0d result words (%0d singular, %0d saturated)",
             matrices, words_seen, sing_seen, sat_seen);
    if (errors == 0) begin
      $display("matrix_inverse_4x4_tb: done, clean");
    end else begin
      $display("matrix_inverse_4x4_tb: done, errors");
    end
    $finish;
  end
endmodule
